// ===== src/lcsp_pkg.sv =====
// Shared types and constants of the lane change speed planner.
// No dependencies; every other file of the block imports it.
`default_nettype none

package lcsp_pkg;

    // Field widths
    localparam int D_W     = 11;
    localparam int V_W     = 14;
    localparam int S_W     = 19;
    localparam int PLEN_W  = 6;
    localparam int GAP_W   = 16;
    localparam int STEP_W  = 12;
    localparam int SPEED_W = 16;
    localparam int LANE_W  = 2;

    // Derived internal widths
    localparam int BAND_W  = 4;          // lane band of a lateral offset, -4..3
    localparam int DIFF_W  = S_W + 1;    // other_s - ref, signed
    localparam int SQ_W    = 2 * V_W;    // vx^2 + vy^2 <= 2^27
    localparam int SPD_W   = V_W;        // floor(sqrt(sq)) <= 11585
    localparam int PROD_W  = 20;         // path_length * speed < 2^20
    localparam int Q_W     = 14;         // product / 50 < 2^14

    // floor(x / 50) as (x * DIV50_MUL) >> DIV50_SHIFT, exact for x < 2^20
    localparam int DIV50_MUL_W = 21;
    localparam logic [DIV50_MUL_W-1:0] DIV50_MUL = 21'd1342178;
    localparam int DIV50_SHIFT = 26;

    // Register map, index = paddr[3:2]
    localparam logic [1:0] REG_FOLLOW_DISTANCE = 2'd0;
    localparam logic [1:0] REG_SPEED_STEP      = 2'd1;
    localparam logic [1:0] REG_SPEED_LIMIT     = 2'd2;

    localparam logic [GAP_W-1:0]   RST_FOLLOW_DISTANCE = 16'd1920;
    localparam logic [STEP_W-1:0]  RST_SPEED_STEP      = 12'd224;
    localparam logic [SPEED_W-1:0] RST_SPEED_LIMIT     = 16'd49500;

    // Lanes
    localparam logic [LANE_W-1:0] LANE_LEFT  = 2'd0;
    localparam logic [LANE_W-1:0] LANE_MID   = 2'd1;
    localparam logic [LANE_W-1:0] LANE_RIGHT = 2'd2;

    // Classified item, front to back
    typedef struct packed {
        logic                     car_present;
        logic                     frame_end;
        logic [PLEN_W-1:0]        path_length;
        logic signed [BAND_W-1:0] band;      // floor(d / 4 m)
        logic                     band_ok;   // d not on a lane boundary
        logic signed [DIFF_W-1:0] diff;      // other_s - ref
        logic [DIFF_W-1:0]        abs_diff;  // |other_s - ref|
        logic [SQ_W-1:0]          sq;        // vx^2 + vy^2
    } t_item;

    typedef struct packed {
        logic [GAP_W-1:0]   follow_distance;
        logic [STEP_W-1:0]  speed_step;
        logic [SPEED_W-1:0] speed_limit;
    } t_cfg;

    typedef struct packed {
        logic [LANE_W-1:0]  lane_out;
        logic [SPEED_W-1:0] target_speed;
        logic               blocked_ahead;
    } t_result;

endpackage

`default_nettype wire

// ===== src/lcsp_in_if.sv =====
// Input channel of the lane change speed planner: one sensed car per transaction.
// Depends on lcsp_pkg for field widths.
`default_nettype none

interface lcsp_in_if;
    import lcsp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  car_present;
    logic                  frame_end;
    logic [S_W-1:0]        ego_s;
    logic [S_W-1:0]        path_end_s;
    logic [PLEN_W-1:0]     path_length;
    logic signed [D_W-1:0] other_d;
    logic signed [V_W-1:0] other_vx;
    logic signed [V_W-1:0] other_vy;
    logic [S_W-1:0]        other_s;

    modport source (
        output valid, car_present, frame_end, ego_s, path_end_s, path_length,
               other_d, other_vx, other_vy, other_s,
        input  ready
    );

    modport sink (
        input  valid, car_present, frame_end, ego_s, path_end_s, path_length,
               other_d, other_vx, other_vy, other_s,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/lcsp_out_if.sv =====
// Output channel of the lane change speed planner: one decision per transaction.
// Depends on lcsp_pkg for field widths.
`default_nettype none

interface lcsp_out_if;
    import lcsp_pkg::*;

    logic               valid;
    logic               ready;
    logic [LANE_W-1:0]  lane_out;
    logic [SPEED_W-1:0] target_speed;
    logic               blocked_ahead;

    modport source (
        output valid, lane_out, target_speed, blocked_ahead,
        input  ready
    );

    modport sink (
        input  valid, lane_out, target_speed, blocked_ahead,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/lcsp_front.sv =====
// Front end: accepts input transactions and classifies them into t_item.
// Depends on lcsp_pkg and lcsp_in_if.
`default_nettype none

module lcsp_front import lcsp_pkg::*; (
    lcsp_in_if.sink    i_in,
    input  logic       i_q_full,
    output logic       o_push,
    output t_item      o_item
);

    logic [S_W-1:0]           ref_s;
    logic signed [DIFF_W-1:0] diff;
    logic signed [SQ_W-1:0]   vx_e;
    logic signed [SQ_W-1:0]   vy_e;
    logic signed [SQ_W-1:0]   vx2;
    logic signed [SQ_W-1:0]   vy2;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    // reference point: end of the previous path if one is left
    assign ref_s = (i_in.path_length != '0) ? i_in.path_end_s : i_in.ego_s;
    assign diff  = signed'({1'b0, i_in.other_s}) - signed'({1'b0, ref_s});

    assign vx_e = SQ_W'(i_in.other_vx);
    assign vy_e = SQ_W'(i_in.other_vy);
    assign vx2  = vx_e * vx_e;
    assign vy2  = vy_e * vy_e;

    always_comb begin
        o_item.car_present = i_in.car_present;
        o_item.frame_end   = i_in.frame_end;
        o_item.path_length = i_in.path_length;
        // lane k holds 4k m < d < 4k+4 m, 4 m = 256 units
        o_item.band        = {i_in.other_d[D_W-1], i_in.other_d[D_W-1:8]};
        o_item.band_ok     = |i_in.other_d[7:0];
        o_item.diff        = diff;
        o_item.abs_diff    = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        o_item.sq          = unsigned'(vx2) + unsigned'(vy2);
    end

endmodule

`default_nettype wire

// ===== src/lcsp_queue.sv =====
// Short FIFO of classified items between front and back.
// Depends on lcsp_pkg.
`default_nettype none

module lcsp_queue import lcsp_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== src/lcsp_back.sv =====
// Back end: serial square root, projection, flag update, lane rule and speed ramp.
// Depends on lcsp_pkg and lcsp_out_if; fed by lcsp_queue.
`default_nettype none

module lcsp_back import lcsp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_empty,
    input  t_item      i_item,
    output logic       o_pop,
    lcsp_out_if.source o_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQRT = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_EVAL = 3'd4;

    localparam int DIVP_W = PROD_W + DIV50_MUL_W;
    localparam logic [SQ_W-1:0] SQRT_BIT0 = SQ_W'(1) << (SQ_W - 2);

    logic [2:0]          r_state, n_state;
    t_item               r_item, n_item;
    logic                r_ego, n_ego;
    logic [SQ_W-1:0]     r_v, n_v;
    logic [SQ_W-1:0]     r_res, n_res;
    logic [SQ_W-1:0]     r_bit, n_bit;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [Q_W-1:0]      r_q, n_q;
    logic [LANE_W-1:0]   r_lane, n_lane;
    logic [SPEED_W-1:0]  r_speed, n_speed;
    logic                r_ahead, n_ahead;
    logic                r_left, n_left;
    logic                r_right, n_right;
    logic                r_out_valid, n_out_valid;
    t_result             r_out, n_out;

    logic signed [BAND_W-1:0] lane_s;
    logic                     pop_ego;
    logic [SQ_W:0]            trial;
    logic [DIVP_W-1:0]        div_full;
    logic signed [DIFF_W:0]   gap_fwd;
    logic                     hit_ahead;
    logic                     near_side;
    logic                     f_ahead, f_left, f_right;
    logic                     load_out;
    logic                     out_free;
    logic [SPEED_W:0]         speed_up;

    assign lane_s   = signed'({2'b00, r_lane});
    assign pop_ego  = i_item.band_ok && (i_item.band == lane_s);
    assign trial    = {1'b0, r_res} + {1'b0, r_bit};
    assign div_full = DIVP_W'(r_prod) * DIVP_W'(DIV50_MUL);
    // projected position minus reference
    assign gap_fwd  = (DIFF_W + 1)'(r_item.diff) + signed'({{(DIFF_W + 1 - Q_W){1'b0}}, r_q});
    assign out_free = !r_out_valid || o_out.ready;
    assign speed_up = {1'b0, r_speed} + (SPEED_W + 1)'(i_cfg.speed_step);

    assign hit_ahead = r_item.car_present && r_ego && (gap_fwd > 0)
                       && (gap_fwd < signed'((DIFF_W + 1)'(i_cfg.follow_distance)));
    assign near_side = r_item.car_present && r_item.band_ok
                       && (r_item.abs_diff < DIFF_W'(i_cfg.follow_distance));

    always_comb begin
        f_ahead = r_ahead || hit_ahead;
        f_left  = r_left;
        f_right = r_right;
        if (near_side) begin
            if (r_item.band == lane_s - 4'sd1) begin
                f_left = 1'b1;
            end else if (r_item.band == lane_s + 4'sd1) begin
                f_right = 1'b1;
            end
        end
    end

    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign load_out = (r_state == S_EVAL) && r_item.frame_end && out_free;

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_ego       = r_ego;
        n_v         = r_v;
        n_res       = r_res;
        n_bit       = r_bit;
        n_prod      = r_prod;
        n_q         = r_q;
        n_lane      = r_lane;
        n_speed     = r_speed;
        n_ahead     = r_ahead;
        n_left      = r_left;
        n_right     = r_right;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;

        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_item = i_item;
                    n_ego  = pop_ego;
                    n_v    = i_item.sq;
                    n_res  = '0;
                    n_bit  = SQRT_BIT0;
                    n_q    = '0;
                    n_state = (i_item.car_present && pop_ego) ? S_SQRT : S_EVAL;
                end
            end
            S_SQRT: begin
                // one result bit per cycle
                if ({1'b0, r_v} >= trial) begin
                    n_v   = r_v - trial[SQ_W-1:0];
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = PROD_W'(r_item.path_length) * PROD_W'(r_res[SPD_W-1:0]);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_q     = div_full[DIV50_SHIFT +: Q_W];
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (!r_item.frame_end) begin
                    n_ahead = f_ahead;
                    n_left  = f_left;
                    n_right = f_right;
                    n_state = S_IDLE;
                end else if (out_free) begin
                    if (f_ahead) begin
                        case (r_lane)
                            LANE_MID: begin
                                if (!f_left) begin
                                    n_lane = LANE_LEFT;
                                end else if (!f_right) begin
                                    n_lane = LANE_RIGHT;
                                end
                            end
                            LANE_LEFT: begin
                                if (!f_right) begin
                                    n_lane = LANE_MID;
                                end
                            end
                            default: begin
                                if (!f_left) begin
                                    n_lane = r_lane - 1'b1;
                                end
                            end
                        endcase
                        n_speed = (r_speed > SPEED_W'(i_cfg.speed_step))
                                  ? r_speed - SPEED_W'(i_cfg.speed_step) : '0;
                    end else if (r_speed < i_cfg.speed_limit) begin
                        n_speed = speed_up[SPEED_W] ? '1 : speed_up[SPEED_W-1:0];
                    end
                    n_out.lane_out      = n_lane;
                    n_out.target_speed  = n_speed;
                    n_out.blocked_ahead = f_ahead;
                    n_out_valid         = 1'b1;
                    n_ahead = 1'b0;
                    n_left  = 1'b0;
                    n_right = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lane      <= LANE_MID;
            r_speed     <= '0;
            r_ahead     <= 1'b0;
            r_left      <= 1'b0;
            r_right     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lane      <= n_lane;
            r_speed     <= n_speed;
            r_ahead     <= n_ahead;
            r_left      <= n_left;
            r_right     <= n_right;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_ego  <= n_ego;
        r_v    <= n_v;
        r_res  <= n_res;
        r_bit  <= n_bit;
        r_prod <= n_prod;
        r_q    <= n_q;
        r_out  <= n_out;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.lane_out      = r_out.lane_out;
    assign o_out.target_speed  = r_out.target_speed;
    assign o_out.blocked_ahead = r_out.blocked_ahead;

`ifndef NO_ASSERTIONS
    a_lane_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lane != 2'd3)
        else $error("lane register out of range");

    a_speed_only_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !load_out |=> $stable(r_speed))
        else $error("speed changed without a decision");

    a_flags_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (!r_ahead && !r_left && !r_right))
        else $error("frame flags not cleared after decision");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state != S_IDLE))
        else $error("back end stayed idle after taking an item");
`endif

endmodule

`default_nettype wire

// ===== src/lane_change_speed_planner.sv =====
// An item in the ego lane goes queue write, pop, 14 square root steps, multiply,
// divide by 50 and evaluate on its way to its decision; any other item goes from
// pop straight to evaluate. The back end, with its serial square root unit, takes
// a new item only when done with the last; a frame end waits for a free output.
// Reset: synchronous, active low; lane 1, speed 0, flags and queue cleared,
// registers back to 30 m gap, 0.224 mph step, 49.5 mph limit.
`default_nettype none

module lane_change_speed_planner import lcsp_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lcsp_in_if.sink     i_in,
    lcsp_out_if.source  o_out,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers, written by the user only while the planner is idle; the block does not enforce it.
    logic [GAP_W-1:0]   r_follow_distance;
    logic [STEP_W-1:0]  r_speed_step;
    logic [SPEED_W-1:0] r_speed_limit;

    logic  cfg_wr;
    t_cfg  cfg;

    // Front to queue to back
    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    t_item front_item;
    t_item back_item;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_follow_distance <= RST_FOLLOW_DISTANCE;
            r_speed_step      <= RST_SPEED_STEP;
            r_speed_limit     <= RST_SPEED_LIMIT;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_FOLLOW_DISTANCE: r_follow_distance <= pwdata[GAP_W-1:0];
                REG_SPEED_STEP:      r_speed_step      <= pwdata[STEP_W-1:0];
                REG_SPEED_LIMIT:     r_speed_limit     <= pwdata[SPEED_W-1:0];
                default: begin
                    // unmapped address, write dropped
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_FOLLOW_DISTANCE: prdata = 32'(r_follow_distance);
            REG_SPEED_STEP:      prdata = 32'(r_speed_step);
            REG_SPEED_LIMIT:     prdata = 32'(r_speed_limit);
            default:             prdata = '0;
        endcase
    end

    assign cfg.follow_distance = r_follow_distance;
    assign cfg.speed_step      = r_speed_step;
    assign cfg.speed_limit     = r_speed_limit;

    // Front: takes each transaction, picks the reference point, finds the
    // lane band, the gap to the reference and the squared speed.
    lcsp_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_item   (front_item)
    );

    // Queue decouples intake from the multi-cycle back end.
    lcsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (back_item)
    );

    // Back: square root and projection for ego-lane cars, frame flags,
    // lane change rule and speed ramp; the result register on o_out lets the back
    // end go on with items that close no frame while a decision waits.
    lcsp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_empty (q_empty),
        .i_item  (back_item),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ===== tb/sv/lcsp_checker.sv =====
// Checker for the lane change speed planner: predicts one decision per frame and
// compares it with the block's output. Depends on lcsp_pkg, lcsp_in_if, lcsp_out_if.
module lcsp_checker import lcsp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lcsp_in_if          i_cars,
    lcsp_out_if         i_plans,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_mismatches,
    output int          o_decisions_due
);

    localparam int LANE_SPAN   = 256;   // 4 m in 1/64 m
    localparam int STEPS_PER_S = 50;    // path points are 20 ms apart
    localparam int SPEED_CEIL  = 65535;
    localparam int MAX_REPORTS = 10;

    t_cfg              cfg;
    logic [LANE_W-1:0] lane;
    logic [SPEED_W-1:0] speed;
    logic              close_ahead;
    logic              busy_left;
    logic              busy_right;
    t_result           decisions_due[$];
    int                mismatches;

    // floor(sqrt(sq)), one result bit per pass
    function automatic longint speed_root(input longint sq);
        longint root;
        longint trial;
        root = 0;
        for (int b = SPD_W - 1; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= sq)
                root = trial;
        end
        return root;
    endfunction

    // open interval: a car on a lane line belongs to neither lane
    function automatic bit in_band(input int d, input int band);
        return d > band * LANE_SPAN && d < (band + 1) * LANE_SPAN;
    endfunction

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    always @(posedge i_clk) begin : track
        t_result got;
        t_result want;
        longint  ref_s;
        longint  os;
        longint  vx;
        longint  vy;
        longint  proj;
        longint  diff;
        longint  gap;
        int      d;
        int      raised;
        if (!i_rst_n) begin
            cfg         = '{RST_FOLLOW_DISTANCE, RST_SPEED_STEP, RST_SPEED_LIMIT};
            lane        = LANE_MID;
            speed       = '0;
            close_ahead = 1'b0;
            busy_left   = 1'b0;
            busy_right  = 1'b0;
            mismatches  = 0;
            decisions_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_FOLLOW_DISTANCE: cfg.follow_distance = i_pwdata[GAP_W-1:0];
                    REG_SPEED_STEP:      cfg.speed_step      = i_pwdata[STEP_W-1:0];
                    REG_SPEED_LIMIT:     cfg.speed_limit     = i_pwdata[SPEED_W-1:0];
                    default: ;
                endcase
            end

            if (i_plans.valid && i_plans.ready) begin
                got.lane_out      = i_plans.lane_out;
                got.target_speed  = i_plans.target_speed;
                got.blocked_ahead = i_plans.blocked_ahead;
                if (decisions_due.size() == 0) begin
                    report($sformatf("unexpected decision: lane %0d speed %0d ahead %0b",
                                     got.lane_out, got.target_speed, got.blocked_ahead));
                end else begin
                    want = decisions_due.pop_front();
                    if (got.lane_out != want.lane_out
                            || got.target_speed != want.target_speed
                            || got.blocked_ahead != want.blocked_ahead)
                        report($sformatf({"decision mismatch: expected lane %0d speed %0d ",
                                          "ahead %0b, got lane %0d speed %0d ahead %0b"},
                                         want.lane_out, want.target_speed, want.blocked_ahead,
                                         got.lane_out, got.target_speed, got.blocked_ahead));
                end
            end

            if (i_cars.valid && i_cars.ready) begin
                ref_s = (i_cars.path_length != 0) ? i_cars.path_end_s : i_cars.ego_s;
                gap   = cfg.follow_distance;
                os    = i_cars.other_s;
                d     = i_cars.other_d;
                if (i_cars.car_present) begin
                    if (in_band(d, int'(lane))) begin
                        vx   = i_cars.other_vx;
                        vy   = i_cars.other_vy;
                        proj = os + (longint'(i_cars.path_length) * speed_root(vx * vx + vy * vy))
                                    / STEPS_PER_S;
                        if (proj > ref_s && proj - ref_s < gap)
                            close_ahead = 1'b1;
                    end
                    diff = (os >= ref_s) ? os - ref_s : ref_s - os;
                    if (diff < gap) begin
                        if (in_band(d, int'(lane) - 1))
                            busy_left = 1'b1;
                        else if (in_band(d, int'(lane) + 1))
                            busy_right = 1'b1;
                    end
                end

                if (i_cars.frame_end) begin
                    if (close_ahead) begin
                        case (lane)
                            LANE_MID: begin
                                if (!busy_left)
                                    lane = LANE_LEFT;
                                else if (!busy_right)
                                    lane = LANE_RIGHT;
                            end
                            LANE_LEFT: begin
                                if (!busy_right)
                                    lane = LANE_MID;
                            end
                            default: begin
                                if (!busy_left)
                                    lane = LANE_MID;
                            end
                        endcase
                        speed = (speed > cfg.speed_step) ? speed - cfg.speed_step : '0;
                    end else if (speed < cfg.speed_limit) begin
                        raised = int'(speed) + int'(cfg.speed_step);
                        speed  = SPEED_W'((raised > SPEED_CEIL) ? SPEED_CEIL : raised);
                    end
                    want.lane_out      = lane;
                    want.target_speed  = speed;
                    want.blocked_ahead = close_ahead;
                    decisions_due.insert(decisions_due.size(), want);
                    close_ahead = 1'b0;
                    busy_left   = 1'b0;
                    busy_right  = 1'b0;
                end
            end
        end
        o_decisions_due <= decisions_due.size();
        o_mismatches    <= mismatches;
    end

endmodule

// ===== tb/sv/lane_change_speed_planner_tb.sv =====
// Top of the lane change speed planner bench: clock, reset, car and APB stimulus,
// result backpressure and the verdict. Depends on lcsp_pkg, the two channel
// interfaces, lcsp_checker and the block itself.
module lane_change_speed_planner_tb;
    import lcsp_pkg::*;

    localparam int IDLE_PCT       = 24;    // chance per cycle that a side idles
    localparam int BURST_FIRST    = 300;   // cars sent while the source never idles
    localparam int BURST_LAST     = 400;
    localparam int SINK_BURST_LO  = 100;   // decisions taken while the sink never idles
    localparam int SINK_BURST_HI  = 130;
    localparam int HOLD_AFTER     = 40;    // decisions taken before the long hold
    localparam int HOLD_CYCLES    = 400;   // long hold, fills the block and stalls input
    localparam int DRAIN_CYCLES   = 80;    // worst ego-lane latency plus queued cars
    localparam int STALL_LIMIT    = 4000;  // cycles with no transaction at all
    localparam int PHASE_CARS     = 100;
    localparam int EGO            = 1000;

    // one sensed car as the input channel carries it
    typedef struct packed {
        logic                  car_present;
        logic                  frame_end;
        logic [S_W-1:0]        ego_s;
        logic [S_W-1:0]        path_end_s;
        logic [PLEN_W-1:0]     path_length;
        logic signed [D_W-1:0] other_d;
        logic signed [V_W-1:0] other_vx;
        logic signed [V_W-1:0] other_vy;
        logic [S_W-1:0]        other_s;
    } t_car;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int decisions_due;
    int decisions_taken = 0;   // output transactions seen so far
    int cars_sent = 0;         // input transactions accepted so far
    int quiet_cycles = 0;

    lcsp_in_if  car_if ();
    lcsp_out_if plan_if ();

    lane_change_speed_planner u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (car_if),
        .o_out   (plan_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lcsp_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cars          (car_if),
        .i_plans         (plan_if),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_mismatches    (mismatches),
        .o_decisions_due (decisions_due)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: any transaction on either channel or the APB port resets it.
    always @(posedge i_clk) begin
        if (plan_if.valid && plan_if.ready)
            decisions_taken <= decisions_taken + 1;
        if ((car_if.valid && car_if.ready) || (plan_if.valid && plan_if.ready) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL lane_change_speed_planner");
                $finish;
            end
        end
    end

    // Decision sink: random idling, a stretch of steady ready, and one long hold
    // early on so the block backs up into its input channel.
    initial begin : decision_sink
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        plan_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                plan_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                plan_if.ready <= 1'b0;
            end else if (!held && decisions_taken >= HOLD_AFTER) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
                plan_if.ready <= 1'b0;
            end else begin
                plan_if.ready <= (decisions_taken >= SINK_BURST_LO
                                  && decisions_taken < SINK_BURST_HI)
                                 || $urandom_range(0, 99) >= IDLE_PCT;
            end
        end
    end

    function automatic t_car make_car(input bit present, input bit fe, input int ego,
                                      input int end_s, input int plen, input int d,
                                      input int vx, input int vy, input int os);
        t_car c;
        c.car_present = present;
        c.frame_end   = fe;
        c.ego_s       = S_W'(ego);
        c.path_end_s  = S_W'(end_s);
        c.path_length = PLEN_W'(plen);
        c.other_d     = D_W'(d);
        c.other_vx    = V_W'(vx);
        c.other_vy    = V_W'(vy);
        c.other_s     = S_W'(os);
        return c;
    endfunction

    // fully random bits in every field
    function automatic t_car noise_car();
        return make_car($urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom);
    endfunction

    // Plausible car around the frame's reference position: any of the five bands
    // the rule looks at, sometimes exactly on a lane line. Slow cars sit within
    // the gap so ahead and side hits are common; fast ones start far enough back
    // that the projection over the path can carry them into the gap.
    function automatic t_car traffic_car(input bit fe, input int ego, input int end_s,
                                         input int plen, input int ref_s, input int gap);
        int band;
        int d;
        int off;
        int vmax;
        bit present;
        band    = int'($urandom_range(0, 4)) - 1;
        d       = band * 256 + (($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, 255)));
        present = fe ? 1'($urandom_range(0, 1)) : 1'b1;
        if ($urandom_range(0, 1)) begin
            vmax = 40;
            off  = int'($urandom_range(0, 2 * gap + 80)) - (gap + 40);
        end else begin
            vmax = 8192;
            off  = int'($urandom_range(0, 2 * gap + 15100)) - (gap + 15000);
        end
        return make_car(present, fe, ego, end_s, plen, d,
                        int'($urandom_range(0, 2 * vmax - 1)) - vmax,
                        int'($urandom_range(0, 2 * vmax - 1)) - vmax, ref_s + off);
    endfunction

    // Offer one car and hold it until the block takes it. Valid stays high
    // straight into the next car unless the source decides to idle.
    task automatic offer_car(input t_car c);
        while (!(cars_sent >= BURST_FIRST && cars_sent < BURST_LAST)
               && $urandom_range(0, 99) < IDLE_PCT) begin
            car_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        car_if.valid       <= 1'b1;
        car_if.car_present <= c.car_present;
        car_if.frame_end   <= c.frame_end;
        car_if.ego_s       <= c.ego_s;
        car_if.path_end_s  <= c.path_end_s;
        car_if.path_length <= c.path_length;
        car_if.other_d     <= c.other_d;
        car_if.other_vx    <= c.other_vx;
        car_if.other_vy    <= c.other_vy;
        car_if.other_s     <= c.other_s;
        do @(posedge i_clk); while (!car_if.ready);
        cars_sent++;
    endtask

    // Setup cycle, then access cycle; the register takes pwdata on the access edge.
    // Psel then drops, so back-to-back writes each get a fresh setup cycle.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop offering, wait for every outstanding decision, then let cars that
    // make no decision drain out of the back end.
    task automatic settle();
        car_if.valid <= 1'b0;
        @(posedge i_clk);
        while (decisions_due != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Frames of zero to five cars plus a closing transaction; one car in ten
    // before it is pure noise. Ego context is shared by all cars of a frame but the noise cars.
    task automatic run_traffic(input int n_cars, input int gap);
        int target;
        int ego;
        int end_s;
        int plen;
        int ref_s;
        target = cars_sent + n_cars;
        while (cars_sent < target) begin
            ego   = $urandom_range(0, 524287);
            plen  = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 63);
            end_s = (ego + $urandom_range(0, 3000)) % 524288;
            ref_s = (plen != 0) ? end_s : ego;
            repeat ($urandom_range(0, 5)) begin
                if ($urandom_range(0, 9) == 0)
                    offer_car(noise_car());
                else
                    offer_car(traffic_car(1'b0, ego, end_s, plen, ref_s, gap));
            end
            offer_car(traffic_car(1'b1, ego, end_s, plen, ref_s, gap));
        end
    endtask

    // New settings while idle; with ramp set, a run of empty frames first drives
    // the speed up against the 16-bit ceiling.
    task automatic run_phase(input t_cfg c, input bit ramp);
        t_car empty;
        settle();
        write_reg(REG_FOLLOW_DISTANCE, 32'(c.follow_distance));
        write_reg(REG_SPEED_STEP, 32'(c.speed_step));
        write_reg(REG_SPEED_LIMIT, 32'(c.speed_limit));
        if (ramp) begin
            repeat (20) begin
                empty = noise_car();
                empty.car_present = 1'b0;
                empty.frame_end   = 1'b1;
                offer_car(empty);
            end
        end
        run_traffic(PHASE_CARS, int'(c.follow_distance));
    endtask

    initial begin : stimulus
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        car_if.valid        <= 1'b0;
        car_if.car_present  <= 1'b0;
        car_if.frame_end    <= 1'b0;
        car_if.ego_s        <= '0;
        car_if.path_end_s   <= '0;
        car_if.path_length  <= '0;
        car_if.other_d      <= '0;
        car_if.other_vx     <= '0;
        car_if.other_vy     <= '0;
        car_if.other_s      <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed walk through the lane rule at reset settings (30 m gap).
        // Empty frame: speed ramps up by one step.
        offer_car(make_car(0, 1, EGO, 0, 0, 0, 0, 0, 0));
        // Car close ahead on the frame-ending transaction: go left, speed floors at 0.
        offer_car(make_car(1, 1, EGO, 0, 0, 384, 0, 0, EGO + 100));
        // Lane 0: left band lies off the road, flagged but ignored.
        offer_car(make_car(1, 0, EGO, 0, 0, -128, 0, 0, EGO));
        // Fastest car, full path, projected just past the path end.
        offer_car(make_car(1, 0, 60000, 200000, 63, 128, -8192, -8192, 185413));
        // Right lane taken: stay in lane 0.
        offer_car(make_car(1, 1, EGO, 0, 0, 384, 0, 0, EGO + 5));
        // Car on the lane line belongs to no lane.
        offer_car(make_car(1, 1, EGO, 0, 0, 256, 0, 0, EGO + 5));
        // Blocked in lane 0 with the right free: back to the middle.
        offer_car(make_car(1, 1, EGO, 0, 0, 100, 0, 0, EGO + 50));
        // Middle lane, left taken, ahead one unit inside the gap: go right.
        offer_car(make_car(1, 0, EGO, 0, 0, 1, 0, 0, EGO));
        offer_car(make_car(1, 1, EGO, 0, 0, 511, 0, 0, EGO + 1919));
        // Lane 2: right band off the road; ahead exactly at the gap is not close.
        offer_car(make_car(1, 0, EGO, 0, 0, 1023, 0, 0, EGO - 5));
        offer_car(make_car(1, 1, EGO, 0, 0, 600, 0, 0, EGO + 1920));
        // Lane 2 blocked with the left taken: stay.
        offer_car(make_car(1, 0, EGO, 0, 0, 300, 0, 0, EGO + 10));
        offer_car(make_car(1, 1, EGO, 0, 0, 513, 0, 0, EGO + 1));
        // Lane 2 blocked with the left free: middle.
        offer_car(make_car(1, 1, EGO, 0, 0, 700, 0, 0, EGO + 2));
        // Boxed in on both sides: stay in the middle.
        offer_car(make_car(1, 0, EGO, 0, 0, 200, 0, 0, EGO - 1919));
        offer_car(make_car(1, 0, EGO, 0, 0, 700, 0, 0, EGO + 1919));
        offer_car(make_car(1, 1, EGO, 0, 0, 400, 0, 0, EGO + 3));
        // Car just behind and car level with the reference: neither is ahead.
        offer_car(make_car(1, 0, EGO, 0, 0, 400, 0, 0, EGO - 1));
        offer_car(make_car(1, 1, EGO, 0, 0, 400, 0, 0, EGO));
        // Field extremes.
        offer_car(make_car(1, 1, 0, 0, 0, -1024, 8191, -8192, 0));
        offer_car(make_car(1, 1, 524287, 0, 1, 1023, 0, 0, 524287));
        // No car mid frame, then an empty frame end.
        offer_car(make_car(0, 0, 524287, 524287, 63, -1, -1, -1, 524287));
        offer_car(make_car(0, 1, 0, 524287, 63, 1023, 8191, 8191, 0));

        // Random phases, extremes first.
        run_phase('{16'd1920, 12'd4095, 16'd65535}, 1'b1);
        run_phase('{16'd0, 12'd0, 16'd0}, 1'b0);
        run_phase('{16'd65535, 12'd4095, 16'd0}, 1'b0);
        run_phase('{RST_FOLLOW_DISTANCE, RST_SPEED_STEP, RST_SPEED_LIMIT}, 1'b0);
        run_phase('{GAP_W'($urandom_range(64, 4000)), STEP_W'($urandom),
                    SPEED_W'($urandom)}, 1'b0);
        run_phase('{GAP_W'($urandom), STEP_W'($urandom), SPEED_W'($urandom)}, 1'b0);

        settle();
        if (mismatches == 0 && decisions_due == 0)
            $display("PASS lane_change_speed_planner");
        else
            $display("FAIL lane_change_speed_planner");
        $finish;
    end

endmodule
